// ===== hdl/arpc_pkg.sv =====
// arp cache responder package: widths, command and status codes, table geometry
// no dependencies
package arpc_pkg;
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {
		CMD_RECEIVE = 3'd0,
		CMD_RESOLVE_IP = 3'd1,
		CMD_RESOLVE_MAC = 3'd2,
		CMD_ADD = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_FOUND_INVALID = 4'd1;
	localparam logic [3:0] ST_NO_ENTRY = 4'd2;
	localparam logic [3:0] ST_TABLE_FULL = 4'd3;
	localparam logic [3:0] ST_BAD_LEN = 4'd4;
	localparam logic [3:0] ST_BAD_TYPE = 4'd5;
	localparam logic [3:0] ST_BAD_HLEN = 4'd6;
	localparam logic [3:0] ST_BAD_PLEN = 4'd7;
	localparam logic [3:0] ST_NOT_FOR_US = 4'd8;
	localparam logic [3:0] ST_REPLY_RECEIVED = 4'd9;
	localparam logic [3:0] ST_BAD_OP = 4'd10;
	localparam logic [3:0] ST_NOT_IMPLEMENTED = 4'd11;

	localparam logic [0:0] REG_LOCAL_IP = 1'b0;
	localparam logic [0:0] REG_LOCAL_MAC = 1'b1;

	// table write port from the sequencer
	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		logic [31:0] ip;
		logic [47:0] mac;
	} tbl_wr_t;
endpackage

// ===== hdl/arp_cache_responder_unit.sv =====
// arp cache responder top level: config registers, sequencer and table
// depends on arpc_pkg, arpc_table, arpc_seq
//
// usage
//   in channel (in_valid/in_ready) takes one command request with packet fields.
//   out channel (out_valid/out_ready) returns exactly one result per request.
//   cfg channel (cfg_valid/cfg_ready, always ready) writes local_ip (index 0)
//   and local_mac (index 1); only while idle, kept by the user, not the block.
// sequencing
//   lookup commands (resolve, add, accepted receive) compare one table entry
//   per cycle through the single read port, then the matched entry is
//   refetched and resolved or written back.
//   rejected receive and unknown commands give their result straight from
//   idle; clear passes through the done state first.
//   one request is in flight at a time; the next is taken the cycle after the
//   result has been handed off.
// reset
//   all entries invalid (read as zero addresses), config registers zero.
//   a stalled result holds on the out channel until taken.
module arp_cache_responder_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] command,
	input logic [15:0] msg_len,
	input logic [15:0] hw_type,
	input logic [15:0] proto_type,
	input logic [7:0] hw_addr_len,
	input logic [7:0] proto_addr_len,
	input logic [15:0] opcode,
	input logic [47:0] peer_mac,
	input logic [31:0] peer_ip,
	input logic [31:0] target_ip,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [47:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] status,
	output logic [4:0] slot_index,
	output logic [47:0] resolved_mac,
	output logic [31:0] resolved_ip,
	output logic send_reply,
	output logic [47:0] reply_dest_mac,
	output logic [31:0] reply_dest_ip
);
	import arpc_pkg::*;

	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0] rd_ip;
	logic [47:0] rd_mac;
	logic rd_valid;
	tbl_wr_t wr;
	logic clear;

	assign cfg_ready = 1'b1;

	// config registers; local_mac is stored but the sequencer does not use it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
			local_mac_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOCAL_IP: local_ip_q <= cfg_data[31:0];
				REG_LOCAL_MAC: local_mac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	arpc_seq u_seq (
		.clk, .arst_n, .in_valid, .in_ready, .command, .msg_len, .hw_type,
		.proto_type, .hw_addr_len, .proto_addr_len, .opcode, .peer_mac,
		.peer_ip, .target_ip, .local_ip(local_ip_q), .out_valid, .out_ready,
		.status, .slot_index, .resolved_mac, .resolved_ip, .send_reply,
		.reply_dest_mac, .reply_dest_ip, .rd_addr, .rd_ip, .rd_mac, .rd_valid,
		.wr, .clear
	);

	arpc_table u_tbl (
		.clk, .arst_n, .rd_addr, .rd_ip, .rd_mac, .rd_valid, .wr, .clear
	);

	// a reply is only raised with an ok status
	a_reply_dest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_reply |-> status == ST_OK)
		else $error("reply with non-ok status");
	// table is never written while a result waits
	a_no_wr_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !wr.en)
		else $error("table write during result hold");
	// a stalled result stays on the out channel
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
endmodule

// ===== hdl/arpc_table.sv =====
// arp table storage: ip/mac memory with one registered read port, valid flags
// depends on arpc_pkg
module arpc_table (
	input logic clk,
	input logic arst_n,
	input logic [arpc_pkg::IDX_W-1:0] rd_addr,
	output logic [31:0] rd_ip,
	output logic [47:0] rd_mac,
	output logic rd_valid,
	input arpc_pkg::tbl_wr_t wr,
	input logic clear
);
	import arpc_pkg::*;

	logic [79:0] mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [79:0] rd_data_q;
	logic rd_vld_q;

	// memory: write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.ip, wr.mac};
		end
		rd_data_q <= mem[rd_addr];
	end

	// valid flags; an invalid entry reads as zero addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr] && !(wr.en && wr.addr == rd_addr) ? 1'b1
				: (wr.en && wr.addr == rd_addr) ? 1'b0 : 1'b0;
			if (clear) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	// written entries are never cleared in memory; valid masks them
	assign rd_valid = rd_vld_q;
	assign rd_ip = rd_vld_q ? rd_data_q[79:48] : 32'd0;
	assign rd_mac = rd_vld_q ? rd_data_q[47:0] : 48'd0;
endmodule

// ===== hdl/arpc_seq.sv =====
// arp command sequencer: packet checks, linear table scan, add, result register
// depends on arpc_pkg, drives arpc_table ports
module arpc_seq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] command,
	input logic [15:0] msg_len,
	input logic [15:0] hw_type,
	input logic [15:0] proto_type,
	input logic [7:0] hw_addr_len,
	input logic [7:0] proto_addr_len,
	input logic [15:0] opcode,
	input logic [47:0] peer_mac,
	input logic [31:0] peer_ip,
	input logic [31:0] target_ip,
	input logic [31:0] local_ip,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] status,
	output logic [4:0] slot_index,
	output logic [47:0] resolved_mac,
	output logic [31:0] resolved_ip,
	output logic send_reply,
	output logic [47:0] reply_dest_mac,
	output logic [31:0] reply_dest_ip,
	output logic [arpc_pkg::IDX_W-1:0] rd_addr,
	input logic [31:0] rd_ip,
	input logic [47:0] rd_mac,
	input logic rd_valid,
	output arpc_pkg::tbl_wr_t wr,
	output logic clear
);
	import arpc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FETCH, S_DONE} state_t;

	state_t state_q;
	logic [2:0] cmd_q;
	logic [15:0] op_q;
	logic [47:0] mac_q;
	logic [31:0] ip_q;
	logic [CNT_W-1:0] addr_q;
	logic [CNT_W-1:0] cmp_q;
	logic cmp_vld_q;
	logic have_free_q;
	logic [CNT_W-1:0] idx_q;
	logic [3:0] pre_st;
	logic by_mac;
	logic hit;
	logic scan_end;
	logic [CNT_W-1:0] last_cnt;

	assign last_cnt = CNT_W'(TABLE_ENTRIES - 1);
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign by_mac = (cmd_q == CMD_RESOLVE_MAC);
	assign hit = by_mac ? (rd_mac == mac_q) : (rd_ip == ip_q);
	assign rd_addr = addr_q[IDX_W-1:0];
	assign scan_end = cmp_vld_q && (cmp_q == last_cnt);

	// receive checks in priority order
	always_comb begin
		pre_st = ST_OK;
		priority if (msg_len != 16'd28) pre_st = ST_BAD_LEN;
		else if (hw_type != 16'd1) pre_st = ST_BAD_TYPE;
		else if (hw_addr_len != 8'd6) pre_st = ST_BAD_HLEN;
		else if (proto_type != 16'h0800) pre_st = ST_BAD_TYPE;
		else if (proto_addr_len != 8'd4) pre_st = ST_BAD_PLEN;
		else if (target_ip != local_ip) pre_st = ST_NOT_FOR_US;
		else pre_st = ST_OK;
	end

	// write port, clear; add/receive skip a matching invalid entry and a full table
	always_comb begin
		wr = '0;
		wr.addr = idx_q[IDX_W-1:0];
		wr.ip = ip_q;
		wr.mac = mac_q;
		wr.en = (state_q == S_DONE) && (idx_q != CNT_W'(TABLE_ENTRIES))
			&& (cmd_q == CMD_ADD || cmd_q == CMD_RECEIVE)
			&& (status != ST_FOUND_INVALID);
		clear = (state_q == S_DONE) && (cmd_q == CMD_CLEAR);
	end

	// result finish for the add command
	function automatic logic [3:0] add_st(input logic [3:0] s, input logic full);
		if (s == ST_FOUND_INVALID) return ST_NOT_IMPLEMENTED;
		if (full) return ST_TABLE_FULL;
		return ST_OK;
	endfunction

	// sequencer: scan one entry per cycle, then resolve or write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			cmp_vld_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= command;
						op_q <= opcode;
						mac_q <= peer_mac;
						ip_q <= peer_ip;
						addr_q <= '0;
						cmp_q <= '0;
						cmp_vld_q <= 1'b0;
						have_free_q <= 1'b0;
						idx_q <= CNT_W'(TABLE_ENTRIES);
						status <= ST_OK;
						slot_index <= 5'(TABLE_ENTRIES);
						resolved_mac <= '0;
						resolved_ip <= '0;
						send_reply <= 1'b0;
						reply_dest_mac <= '0;
						reply_dest_ip <= '0;
						unique case (command)
							CMD_RECEIVE: begin
								if (pre_st != ST_OK) begin
									status <= pre_st;
									slot_index <= '0;
									out_valid <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_RESOLVE_IP, CMD_RESOLVE_MAC, CMD_ADD: state_q <= S_SCAN;
							CMD_CLEAR: begin
								state_q <= S_DONE;
							end
							default: begin
								status <= ST_NOT_IMPLEMENTED;
								out_valid <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					// read address runs one ahead of the compare
					if (addr_q != last_cnt) addr_q <= addr_q + 1'b1;
					cmp_vld_q <= 1'b1;
					if (cmp_vld_q) cmp_q <= cmp_q + 1'b1;
					if (cmp_vld_q) begin
						if (hit) begin
							idx_q <= cmp_q;
							status <= rd_valid ? ST_OK : ST_FOUND_INVALID;
							addr_q <= cmp_q;
							cmp_vld_q <= 1'b0;
							state_q <= S_FETCH;
						end else begin
							if (!have_free_q && !rd_valid) begin
								have_free_q <= 1'b1;
								idx_q <= cmp_q;
							end
							if (scan_end) begin
								status <= ST_NO_ENTRY;
								cmp_vld_q <= 1'b0;
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_FETCH: begin
					// read of the hit entry is issued here; its data is at rd_* in S_DONE
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
					slot_index <= 5'(idx_q);
					unique case (cmd_q)
						CMD_RESOLVE_IP: resolved_mac <= (status == ST_OK) ? rd_mac : '1;
						CMD_RESOLVE_MAC: resolved_ip <= (status == ST_OK) ? rd_ip : '1;
						CMD_ADD: status <= add_st(status, idx_q == CNT_W'(TABLE_ENTRIES));
						CMD_RECEIVE: begin
							if (op_q == 16'd1) begin
								status <= ST_OK;
								send_reply <= 1'b1;
								reply_dest_mac <= mac_q;
								reply_dest_ip <= ip_q;
							end else if (op_q == 16'd2) begin
								status <= ST_REPLY_RECEIVED;
							end else begin
								status <= ST_BAD_OP;
							end
						end
						default: begin
							status <= ST_OK;
							slot_index <= 5'(TABLE_ENTRIES);
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sv/arp_cache_result_checker.sv =====
// result checker for arp_cache_responder_unit: mirrors the table and compares every result
// depends on arpc_pkg
`timescale 1ns / 1ps
module arp_cache_result_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [2:0] command,
	input logic [15:0] msg_len,
	input logic [15:0] hw_type,
	input logic [15:0] proto_type,
	input logic [7:0] hw_addr_len,
	input logic [7:0] proto_addr_len,
	input logic [15:0] opcode,
	input logic [47:0] peer_mac,
	input logic [31:0] peer_ip,
	input logic [31:0] target_ip,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [47:0] cfg_data,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] status,
	input logic [4:0] slot_index,
	input logic [47:0] resolved_mac,
	input logic [31:0] resolved_ip,
	input logic send_reply,
	input logic [47:0] reply_dest_mac,
	input logic [31:0] reply_dest_ip,
	output int errors,
	output int pending
);
	import arpc_pkg::*;

	typedef struct {
		logic [3:0] status;
		logic [4:0] slot;
		logic [47:0] rmac;
		logic [31:0] rip;
		logic send;
		logic [47:0] dmac;
		logic [31:0] dip;
	} arp_result_t;

	arp_result_t awaited_results[$];

	logic [31:0] my_ip;
	logic [31:0] cache_ip[TABLE_ENTRIES];
	logic [47:0] cache_mac[TABLE_ENTRIES];
	logic cache_valid[TABLE_ENTRIES];

	// linear scan: first address match wins, else first free slot
	function automatic logic [3:0] scan_cache(input bit by_mac, input logic [47:0] key,
			output logic [4:0] slot);
		bit got_free;
		bit hit;
		got_free = 0;
		slot = 5'(TABLE_ENTRIES);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit = by_mac ? (cache_mac[i] == key) : ({16'h0, cache_ip[i]} == key);
			if (hit) begin
				slot = 5'(i);
				return cache_valid[i] ? ST_OK : ST_FOUND_INVALID;
			end
			if (!got_free && !cache_valid[i]) begin
				got_free = 1;
				slot = 5'(i);
			end
		end
		return ST_NO_ENTRY;
	endfunction

	function automatic logic [3:0] learn_entry(input logic [31:0] ip, input logic [47:0] mac,
			output logic [4:0] slot);
		logic [3:0] st;
		st = scan_cache(1'b0, {16'h0, ip}, slot);
		if (st == ST_FOUND_INVALID)
			return ST_NOT_IMPLEMENTED;
		if (slot >= TABLE_ENTRIES)
			return ST_TABLE_FULL;
		cache_ip[slot[3:0]] = ip;
		cache_mac[slot[3:0]] = mac;
		cache_valid[slot[3:0]] = 1'b1;
		return ST_OK;
	endfunction

	// expected result of one request, updating the mirrored table
	function automatic arp_result_t predict_result();
		arp_result_t r;
		r = '{default: '0};
		case (command)
			CMD_RECEIVE: begin
				if (msg_len != 16'd28) r.status = ST_BAD_LEN;
				else if (hw_type != 16'd1) r.status = ST_BAD_TYPE;
				else if (hw_addr_len != 8'd6) r.status = ST_BAD_HLEN;
				else if (proto_type != 16'h0800) r.status = ST_BAD_TYPE;
				else if (proto_addr_len != 8'd4) r.status = ST_BAD_PLEN;
				else if (target_ip != my_ip) r.status = ST_NOT_FOR_US;
				else begin
					void'(learn_entry(peer_ip, peer_mac, r.slot));
					if (opcode == 16'd1) begin
						r.status = ST_OK;
						r.send = 1'b1;
						r.dmac = peer_mac;
						r.dip = peer_ip;
					end else if (opcode == 16'd2) begin
						r.status = ST_REPLY_RECEIVED;
					end else begin
						r.status = ST_BAD_OP;
					end
				end
			end
			CMD_RESOLVE_IP: begin
				r.status = scan_cache(1'b0, {16'h0, peer_ip}, r.slot);
				r.rmac = (r.status == ST_OK) ? cache_mac[r.slot[3:0]] : '1;
			end
			CMD_RESOLVE_MAC: begin
				r.status = scan_cache(1'b1, peer_mac, r.slot);
				r.rip = (r.status == ST_OK) ? cache_ip[r.slot[3:0]] : '1;
			end
			CMD_ADD: r.status = learn_entry(peer_ip, peer_mac, r.slot);
			CMD_CLEAR: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					cache_ip[i] = '0;
					cache_mac[i] = '0;
					cache_valid[i] = 1'b0;
				end
				r.status = ST_OK;
				r.slot = 5'(TABLE_ENTRIES);
			end
			default: begin
				r.status = ST_NOT_IMPLEMENTED;
				r.slot = 5'(TABLE_ENTRIES);
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// mirror state, compare results, queue predictions
	always @(posedge clk or negedge arst_n) begin
		arp_result_t w;
		if (!arst_n) begin
			my_ip = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				cache_ip[i] = '0;
				cache_mac[i] = '0;
				cache_valid[i] = 1'b0;
			end
			awaited_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LOCAL_IP) my_ip = cfg_data[31:0];
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t result with no request outstanding", $realtime);
					errors++;
				end else begin
					w = awaited_results.pop_front();
					if (status !== w.status)
						report_mismatch("status", 48'(status), 48'(w.status));
					if (slot_index !== w.slot)
						report_mismatch("slot_index", 48'(slot_index), 48'(w.slot));
					if (resolved_mac !== w.rmac)
						report_mismatch("resolved_mac", resolved_mac, w.rmac);
					if (resolved_ip !== w.rip)
						report_mismatch("resolved_ip", 48'(resolved_ip), 48'(w.rip));
					if (send_reply !== w.send)
						report_mismatch("send_reply", 48'(send_reply), 48'(w.send));
					if (reply_dest_mac !== w.dmac)
						report_mismatch("reply_dest_mac", reply_dest_mac, w.dmac);
					if (reply_dest_ip !== w.dip)
						report_mismatch("reply_dest_ip", 48'(reply_dest_ip), 48'(w.dip));
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(predict_result());
			pending = awaited_results.size();
		end
	end
endmodule

// ===== tb/sv/arp_cache_responder_unit_test.sv =====
// testbench top for arp_cache_responder_unit: clock, reset, requests, config and verdict
// depends on arpc_pkg, arp_cache_responder_unit, arp_cache_result_checker
`timescale 1ns / 1ps
module arp_cache_responder_unit_test;
	import arpc_pkg::*;

	typedef struct {
		logic [2:0] command;
		logic [15:0] msg_len;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0] hw_addr_len;
		logic [7:0] proto_addr_len;
		logic [15:0] opcode;
		logic [47:0] peer_mac;
		logic [31:0] peer_ip;
		logic [31:0] target_ip;
	} arp_request_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [2:0] command;
	logic [15:0] msg_len, hw_type, proto_type, opcode;
	logic [7:0] hw_addr_len, proto_addr_len;
	logic [47:0] peer_mac;
	logic [31:0] peer_ip, target_ip;
	logic cfg_valid, cfg_ready;
	logic [0:0] cfg_index;
	logic [47:0] cfg_data;
	logic out_valid, out_ready;
	logic [3:0] status;
	logic [4:0] slot_index;
	logic [47:0] resolved_mac, reply_dest_mac;
	logic [31:0] resolved_ip, reply_dest_ip;
	logic send_reply;
	int errors, pending;

	bit no_stall;
	logic [31:0] cur_ip;
	logic [31:0] ip_pool[24];
	logic [47:0] mac_pool[24];

	arp_cache_responder_unit dut (.*);
	arp_cache_result_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("arp_cache_responder_unit_test: errors");
		$finish;
	end

	// result side: random stall before taking each result
	initial begin
		int w;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			w = no_stall ? 0 : $urandom_range(0, 7);
			if (w > 0) begin
				out_ready <= 0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one request; valid stays high afterwards unless the next gap lowers it
	task automatic send_request(input arp_request_t r);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		command <= r.command;
		msg_len <= r.msg_len;
		hw_type <= r.hw_type;
		proto_type <= r.proto_type;
		hw_addr_len <= r.hw_addr_len;
		proto_addr_len <= r.proto_addr_len;
		opcode <= r.opcode;
		peer_mac <= r.peer_mac;
		peer_ip <= r.peer_ip;
		target_ip <= r.target_ip;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
	endtask

	// idle until every result is back, then cover the longest lookup
	task automatic wait_idle();
		in_valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_addresses(input logic [31:0] ip, input logic [47:0] mac);
		cur_ip = ip;
		cfg_index <= REG_LOCAL_IP;
		cfg_data <= {16'h0, ip};
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_LOCAL_MAC;
		cfg_data <= mac;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic arp_request_t good_packet(input logic [15:0] op, input logic [31:0] ip,
			input logic [47:0] mac);
		arp_request_t r;
		r = '{CMD_RECEIVE, 16'd28, 16'd1, 16'h0800, 8'd6, 8'd4, op, mac, ip, cur_ip};
		return r;
	endfunction

	function automatic arp_request_t lookup_req(input cmd_t c, input logic [31:0] ip,
			input logic [47:0] mac);
		arp_request_t r;
		r = '{c, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom), mac, ip, $urandom};
		return r;
	endfunction

	function automatic arp_request_t noise_req();
		arp_request_t r;
		r = '{3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom), 16'($urandom), 48'({$urandom, $urandom}),
			$urandom, $urandom};
		return r;
	endfunction

	// mostly well-formed traffic over a small address pool, some broken or noise
	function automatic arp_request_t random_req();
		arp_request_t r;
		int k, p, q;
		k = $urandom_range(0, 99);
		p = $urandom_range(0, 23);
		q = $urandom_range(0, 23);
		if (k < 30) begin
			r = good_packet($urandom_range(0, 9) < 6 ? 16'd1 :
				($urandom_range(0, 3) != 0 ? 16'd2 : 16'($urandom)), ip_pool[p], mac_pool[p]);
			if ($urandom_range(0, 9) == 0) r.target_ip = $urandom;
		end else if (k < 40) begin
			r = good_packet(16'd1, ip_pool[p], mac_pool[p]);
			case ($urandom_range(0, 4))
				0: r.msg_len = 16'($urandom);
				1: r.hw_type = 16'($urandom);
				2: r.hw_addr_len = 8'($urandom);
				3: r.proto_type = 16'($urandom);
				default: r.proto_addr_len = 8'($urandom);
			endcase
		end else if (k < 60) begin
			r = lookup_req(CMD_RESOLVE_IP, ip_pool[p], mac_pool[q]);
		end else if (k < 70) begin
			r = lookup_req(CMD_RESOLVE_MAC, ip_pool[q], mac_pool[p]);
		end else if (k < 90) begin
			r = lookup_req(CMD_ADD, ip_pool[p], ($urandom_range(0, 3) == 0) ? mac_pool[q] :
				mac_pool[p]);
		end else if (k < 92) begin
			r = lookup_req(CMD_CLEAR, ip_pool[p], mac_pool[p]);
		end else begin
			r = noise_req();
		end
		return r;
	endfunction

	// stimulus
	initial begin
		arp_request_t r;
		in_valid = 0;
		command = '0;
		msg_len = '0;
		hw_type = '0;
		proto_type = '0;
		hw_addr_len = '0;
		proto_addr_len = '0;
		opcode = '0;
		peer_mac = '0;
		peer_ip = '0;
		target_ip = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		no_stall = 0;
		cur_ip = '0;
		for (int i = 0; i < 24; i++) begin
			ip_pool[i] = $urandom;
			mac_pool[i] = 48'({$urandom, $urandom});
		end
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero keys on a cleared table, then every receive check
		send_request(lookup_req(CMD_RESOLVE_IP, 32'h0, 48'h1));
		send_request(lookup_req(CMD_RESOLVE_MAC, 32'h1, 48'h0));
		send_request(lookup_req(CMD_ADD, 32'h0, 48'h5));
		wait_idle();
		set_addresses(32'hC0A8_0001, 48'h0200_0000_0001);
		send_request(good_packet(16'd1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		send_request(good_packet(16'd2, ip_pool[0], mac_pool[0]));
		send_request(good_packet(16'hFFFF, ip_pool[1], mac_pool[1]));
		r = good_packet(16'd1, ip_pool[2], mac_pool[2]); r.msg_len = 16'hFFFF;
		send_request(r);
		r = good_packet(16'd1, ip_pool[2], mac_pool[2]); r.hw_type = 16'd0;
		send_request(r);
		r = good_packet(16'd1, ip_pool[2], mac_pool[2]); r.hw_addr_len = 8'hFF;
		send_request(r);
		r = good_packet(16'd1, ip_pool[2], mac_pool[2]); r.proto_type = 16'hFFFF;
		send_request(r);
		r = good_packet(16'd1, ip_pool[2], mac_pool[2]); r.proto_addr_len = 8'd0;
		send_request(r);
		r = good_packet(16'd1, ip_pool[2], mac_pool[2]); r.target_ip = ~cur_ip;
		send_request(r);
		send_request(lookup_req(CMD_RESOLVE_IP, ip_pool[0], 48'h0));
		send_request(lookup_req(CMD_RESOLVE_MAC, 32'h0, mac_pool[1]));
		send_request(lookup_req(CMD_RESOLVE_IP, ip_pool[5], 48'h0));
		send_request(lookup_req(CMD_ADD, ip_pool[0], mac_pool[9]));
		for (int c = 5; c < 8; c++) begin
			r = noise_req(); r.command = 3'(c);
			send_request(r);
		end
		// fill the table; the last adds of the loop and one more add overflow
		for (int i = 3; i < 18; i++)
			send_request(lookup_req(CMD_ADD, ip_pool[i], mac_pool[i]));
		send_request(lookup_req(CMD_ADD, ip_pool[20], mac_pool[20]));
		send_request(lookup_req(CMD_CLEAR, 32'h0, 48'h0));

		// random phases, each under its own address setting
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			case (ph)
				0: set_addresses(32'h0, 48'h0);
				1: set_addresses(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
				default: set_addresses(ip_pool[$urandom_range(0, 23)],
					48'({$urandom, $urandom}));
			endcase
			no_stall = (ph == 2);
			for (int n = 0; n < 200; n++)
				send_request(random_req());
		end
		wait_idle();
		no_stall = 0;

		if (errors == 0 && pending == 0)
			$display("arp_cache_responder_unit_test: clean");
		else
			$display("arp_cache_responder_unit_test: errors");
		$finish;
	end
endmodule

// ===== arp_cache_responder_unit.f =====
hdl/arpc_pkg.sv
hdl/arpc_table.sv
hdl/arpc_seq.sv
hdl/arp_cache_responder_unit.sv
tb/sv/arp_cache_result_checker.sv
tb/sv/arp_cache_responder_unit_test.sv
